FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the checker file of the project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, switched off while in reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising clock edge, also during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/dirent_pkg.sv
// ---------------------------------------------------------------------------
// dirent_pkg
// Types and constants of the directory record walker.
// ---------------------------------------------------------------------------
package dirent_pkg;

  localparam int unsigned OffsetW = 17;
  localparam int unsigned InodeW  = 32;
  localparam int unsigned RecLenW = 16;
  localparam int unsigned ByteW   = 8;

  localparam logic [OffsetW-1:0] HeaderBytes  = 17'd8;
  localparam logic [OffsetW-1:0] SizeMin      = 17'd1024;
  localparam logic [OffsetW-1:0] SizeMax      = 17'd65536;
  localparam logic [OffsetW-1:0] SizeReset    = 17'd4096;
  localparam logic [ByteW-1:0]   DotChar      = 8'h2E;

  // Byte offsets of the header fields within a record.
  localparam logic [OffsetW-1:0] RelInode3    = 17'd3;
  localparam logic [OffsetW-1:0] RelLenLo     = 17'd4;
  localparam logic [OffsetW-1:0] RelLenHi     = 17'd5;
  localparam logic [OffsetW-1:0] RelNameLen   = 17'd6;
  localparam logic [OffsetW-1:0] RelFileType  = 17'd7;

  // Configuration register map.
  localparam int unsigned AddrW = 3;
  typedef enum logic [0:0] {
    REG_BLOCK_SIZE = 1'b0
  } reg_idx_e;

  // One result item: a name byte with its tags.
  typedef struct packed {
    logic [InodeW-1:0] inode;
    logic [ByteW-1:0]  name_byte;
    logic [ByteW-1:0]  position;
    logic              last;
  } result_t;

  localparam int unsigned QueueDepth = 3;

endpackage

FILE: src/dir_entry_block_parser.sv
// ---------------------------------------------------------------------------
// dir_entry_block_parser
// Walks ext2-style directory records in a byte stream and emits name bytes.
// ---------------------------------------------------------------------------
// Usage: raw block bytes enter on the s_axis channel, one item per byte,
// blocks back to back with block_size bytes each (APB register at offset 0,
// clamped to 1024..65536). Each result item on m_axis carries one name byte,
// the inode of its record and the byte position in the name; tlast marks the
// final byte of a name.
// A byte is parsed in the cycle it is accepted and its results are
// registered into the output queue behind any results already waiting.
// One byte is taken per cycle as long as the output queue (three entries)
// holds at most one result; a two-byte name yields two results for its second byte.
// When the receiver stalls, results stay in the queue and s_axis_tready
// drops once two or more are waiting.
// Reset clears the walk to the start of a block, empties the queue and sets
// block_size to 4096. Write block_size only while no item is in flight.
// ---------------------------------------------------------------------------
module dir_entry_block_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte stream in.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] block_byte
  // Name bytes out.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] entry_inode, [39:32] name_byte,
                                      // [47:40] name_position
  output logic        m_axis_tlast,   // last_of_name
  // Configuration.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [dirent_pkg::AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned OW = dirent_pkg::OffsetW;

  logic [OW-1:0]                   block_size_q;
  logic [OW-1:0]                   offset_q, offset_d;
  logic [OW-1:0]                   rstart_q, rstart_d;
  logic [dirent_pkg::InodeW-1:0]   inode_q, inode_d;
  logic [dirent_pkg::RecLenW-1:0]  reclen_q, reclen_d;
  logic [7:0]                      namelen_q, namelen_d;
  logic [7:0]                      held_q, held_d;
  logic                            stopped_q, stopped_d;

  dirent_pkg::result_t queue_q [dirent_pkg::QueueDepth];
  dirent_pkg::result_t queue_d [dirent_pkg::QueueDepth];
  logic [1:0]                      count_q, count_d;

  logic                            in_acc, out_acc, cfg_wr;
  logic [OW-1:0]                   size, rel, idx, size_left;
  logic [dirent_pkg::RecLenW-1:0]  newlen;
  logic                            wanted;
  logic [1:0]                      n_res;
  dirent_pkg::result_t             res0, res1;
  logic [1:0]                      cnt_pop;
  logic [7:0]                      b;

  assign b       = s_axis_tdata;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign cfg_wr  = psel && penable && pwrite && pready &&
                   (paddr[2] == dirent_pkg::REG_BLOCK_SIZE);

  // Configuration port.
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == dirent_pkg::REG_BLOCK_SIZE) begin
      prdata = {{(32-OW){1'b0}}, block_size_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= dirent_pkg::SizeReset;
    end else if (cfg_wr) begin
      block_size_q <= pwdata[OW-1:0];
    end
  end

  always_comb begin
    priority if (block_size_q < dirent_pkg::SizeMin) begin
      size = dirent_pkg::SizeMin;
    end else if (block_size_q > dirent_pkg::SizeMax) begin
      size = dirent_pkg::SizeMax;
    end else begin
      size = block_size_q;
    end
  end

  assign rel       = offset_q - rstart_q;
  assign idx       = rel - dirent_pkg::HeaderBytes;
  assign size_left = size - rstart_q;
  assign newlen    = {b, reclen_q[7:0]};
  assign wanted    = (inode_q != '0) && (namelen_q != '0) &&
                     ({8'd0, namelen_q} + 16'd8 <= reclen_q);

  // Record walk, one byte per accepted item.
  always_comb begin
    offset_d  = offset_q;
    rstart_d  = rstart_q;
    inode_d   = inode_q;
    reclen_d  = reclen_q;
    namelen_d = namelen_q;
    held_d    = held_q;
    stopped_d = stopped_q;
    n_res     = 2'd0;
    res0      = '{inode: inode_q, name_byte: b, position: idx[7:0], last: 1'b0};
    res1      = '{inode: inode_q, name_byte: b, position: 8'd1, last: 1'b1};

    if (in_acc) begin
      if (!stopped_q) begin
        priority if (rel < dirent_pkg::RelLenLo) begin
          unique case (rel[1:0])
            2'd0: inode_d = {24'd0, b};
            2'd1: inode_d = {inode_q[31:16], b, inode_q[7:0]};
            2'd2: inode_d = {inode_q[31:24], b, inode_q[15:0]};
            default: inode_d = {b, inode_q[23:0]};
          endcase
          if (rel == dirent_pkg::RelInode3 && rstart_q == '0 && inode_d == '0) begin
            stopped_d = 1'b1;
          end
        end else if (rel == dirent_pkg::RelLenLo) begin
          reclen_d = {8'd0, b};
        end else if (rel == dirent_pkg::RelLenHi) begin
          reclen_d = newlen;
          if (newlen < 16'd8 || rstart_q >= size ||
              {1'b0, newlen} > size_left) begin
            stopped_d = 1'b1;
          end
        end else if (rel == dirent_pkg::RelNameLen) begin
          namelen_d = b;
        end else if (rel >= dirent_pkg::HeaderBytes) begin
          if (wanted && idx < {9'd0, namelen_q}) begin
            priority if (namelen_q == 8'd1) begin
              if (b != dirent_pkg::DotChar) begin
                n_res = 2'd1;
                res0  = '{inode: inode_q, name_byte: b, position: 8'd0, last: 1'b1};
              end
            end else if (namelen_q == 8'd2) begin
              if (idx == '0) begin
                held_d = b;
              end else if (!(held_q == dirent_pkg::DotChar &&
                             b == dirent_pkg::DotChar)) begin
                // Two-byte name: the held first byte goes out ahead of this one.
                n_res = 2'd2;
                res0  = '{inode: inode_q, name_byte: held_q, position: 8'd0, last: 1'b0};
              end
            end else begin
              n_res = 2'd1;
              res0  = '{inode: inode_q, name_byte: b, position: idx[7:0],
                        last: (idx + 17'd1 == {9'd0, namelen_q})};
            end
          end
        end else begin
          // File type byte is not used.
          n_res = 2'd0;
        end
        if (!stopped_d && rel >= dirent_pkg::RelFileType &&
            {1'b0, rel} + 18'd1 == {2'd0, reclen_d}) begin
          rstart_d = offset_q + 17'd1;
        end
      end
      if ({1'b0, offset_q} + 18'd1 >= {1'b0, size}) begin
        offset_d  = '0;
        rstart_d  = '0;
        stopped_d = 1'b0;
      end else begin
        offset_d = offset_q + 17'd1;
      end
    end
  end

  // Output queue: shift out at the head, append new results behind the rest.
  assign cnt_pop = count_q - {1'b0, out_acc};

  always_comb begin
    for (int k = 0; k < dirent_pkg::QueueDepth; k++) begin
      if (out_acc && k < dirent_pkg::QueueDepth - 1) begin
        queue_d[k] = queue_q[k+1];
      end else begin
        queue_d[k] = queue_q[k];
      end
      if (n_res != 2'd0 && k == int'(cnt_pop)) begin
        queue_d[k] = res0;
      end
      if (n_res == 2'd2 && k == int'(cnt_pop) + 1) begin
        queue_d[k] = res1;
      end
    end
    count_d = cnt_pop + n_res;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < dirent_pkg::QueueDepth; k++) begin
      queue_q[k] <= queue_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q  <= '0;
      rstart_q  <= '0;
      inode_q   <= '0;
      reclen_q  <= '0;
      namelen_q <= '0;
      held_q    <= '0;
      stopped_q <= 1'b0;
      count_q   <= '0;
    end else begin
      offset_q  <= offset_d;
      rstart_q  <= rstart_d;
      inode_q   <= inode_d;
      reclen_q  <= reclen_d;
      namelen_q <= namelen_d;
      held_q    <= held_d;
      stopped_q <= stopped_d;
      count_q   <= count_d;
    end
  end

  assign s_axis_tready = (count_q <= 2'd1);
  assign m_axis_tvalid = (count_q != 2'd0);
  assign m_axis_tdata  = {queue_q[0].position, queue_q[0].name_byte, queue_q[0].inode};
  assign m_axis_tlast  = queue_q[0].last;

endmodule

FILE: src/dirent_checker.sv
// ---------------------------------------------------------------------------
// dirent_checker
// Port-level checks of the directory record walker.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dirent_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        pready
);

  // A stalled result item must hold its value.
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output item changed")

  // Results only appear after an accepted input item.
  `ASSERT_RST(a_out_cause, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready), "output item without input item")

  // With nothing waiting at the output the input side must be open.
  `ASSERT_RST(a_in_open, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready, "input blocked with empty output")

  // The configuration port never inserts wait states.
  `ASSERT_ALWAYS(a_pready, clk_i, pready, "pready dropped")

endmodule

bind dir_entry_block_parser dirent_checker u_dirent_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .pready       (pready)
);
